### hdl/psc_pkg.sv
`default_nettype none
package psc_pkg;

	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;
	localparam int CAL_W   = 16;
	localparam int RAW_W   = 16;
	localparam int PRESS_W = 26;
	localparam int TEMP_W  = 17;

	typedef struct packed {
		logic [CAL_W-1:0] w1;
		logic [CAL_W-1:0] w2;
		logic [CAL_W-1:0] w3;
		logic [CAL_W-1:0] w4;
	} cal_words_t;

	typedef enum logic [1:0] {
		REG_CAL_ONE   = 2'd0,
		REG_CAL_TWO   = 2'd1,
		REG_CAL_THREE = 2'd2,
		REG_CAL_FOUR  = 2'd3
	} reg_index_t;

	localparam logic [15:0] DT_BASE     = 16'd20224;
	localparam logic [15:0] SENS_BASE   = 16'd24576;
	localparam logic [15:0] D1_BASE     = 16'd7168;
	localparam logic [6:0]  TCO_BASE    = 7'd50;
	localparam logic [10:0] TCO_OFFSET  = 11'd512;
	localparam logic [19:0] PRESS_BASE  = 20'd256000;
	localparam logic [10:0] TEMP_BASE   = 11'd2000;

endpackage
`default_nettype wire

### hdl/psc_if.sv
`default_nettype none
interface psc_sample_if;
	import psc_pkg::*;
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] pressure_raw;
	logic [RAW_W-1:0] temperature_raw;

	modport source (output valid, pressure_raw, temperature_raw, input ready);
	modport sink (input valid, pressure_raw, temperature_raw, output ready);
endinterface

interface psc_result_if;
	import psc_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [PRESS_W-1:0] pressure_out;
	logic signed [TEMP_W-1:0]  temperature_out;

	modport source (output valid, pressure_out, temperature_out, input ready);
	modport sink (input valid, pressure_out, temperature_out, output ready);
endinterface
`default_nettype wire

### hdl/pressure_sensor_compensation_core.sv
// An accepted sample word passes through the registers of stages s1 to s5 in order before its result word.
// Throughput: one sample word per cycle; the five stages fill bubbles
// independently, so a stalled result blocks input only once all are full.
// Reset: asynchronous, clears stage valid bits and the four calibration
// words to zero.
`default_nettype none
module pressure_sensor_compensation_core (
	input  logic                       clk,
	input  logic                       arst_n,
	psc_sample_if.sink                 sample,
	psc_result_if.source               result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [psc_pkg::APB_AW-1:0] paddr,
	input  logic [psc_pkg::APB_DW-1:0] pwdata,
	output logic [psc_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import psc_pkg::*;

	localparam logic signed [28:0] P_MAX = 29'sd33554431;
	localparam logic signed [28:0] P_MIN = -29'sd33554432;
	localparam logic signed [18:0] T_MAX = 19'sd65535;
	localparam logic signed [18:0] T_MIN = -19'sd65536;

	cal_words_t cal;

	logic [14:0] c1;
	logic [11:0] c2;
	logic [9:0]  c3;
	logic [9:0]  c4;
	logic [10:0] c5;
	logic [5:0]  c6;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	logic signed [16:0] dt_s1, d1m_s1;
	logic signed [27:0] sens_term_s2, off_term_s2;
	logic signed [24:0] temp_term_s2;
	logic signed [16:0] d1m_s2;
	logic signed [27:0] s1_s3, o1_s3;
	logic signed [28:0] t10_s3;
	logic signed [16:0] d1m_s3;
	logic signed [44:0] prod_s4;
	logic signed [27:0] o1_s4;
	logic signed [TEMP_W-1:0]  temp_s4;
	logic signed [PRESS_W-1:0] press_s5;
	logic signed [TEMP_W-1:0]  temp_s5;

	logic signed [16:0] dt_c, d1m_c;
	logic signed [10:0] c4m_c;
	logic [6:0]         c6p_c;
	logic [25:0]        sens_base_c;
	logic signed [27:0] s1_c, o1_c;
	logic signed [28:0] t10_c;
	logic signed [18:0] t_full_c;
	logic signed [46:0] n_c;
	logic signed [28:0] p_full_c;

	psc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cal     (cal)
	);

	assign c1 = cal.w1[15:1];
	assign c2 = {cal.w3[5:0], cal.w4[5:0]};
	assign c3 = cal.w4[15:6];
	assign c4 = cal.w3[15:6];
	assign c5 = {cal.w1[0], cal.w2[15:6]};
	assign c6 = cal.w2[5:0];

	assign en_s5 = !v_s5 || result.ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign sample.ready = en_s1;

	assign result.valid           = v_s5;
	assign result.pressure_out    = press_s5;
	assign result.temperature_out = temp_s5;

	always_comb begin
		dt_c  = $signed(17'({1'b0, sample.temperature_raw}) - 17'({c5, 3'b000})
			- 17'(DT_BASE));
		d1m_c = $signed(17'({1'b0, sample.pressure_raw}) - 17'(D1_BASE));
		c4m_c = $signed({1'b0, c4}) - $signed(TCO_OFFSET);
		c6p_c = {1'b0, c6} + TCO_BASE;
		sens_base_c = {16'({1'b0, c1}) + SENS_BASE, 10'b0};
		s1_c  = $signed({2'b00, sens_base_c}) + sens_term_s2;
		o1_c  = $signed({2'b00, c2, 14'b0}) + off_term_s2;
		t10_c = (29'(temp_term_s2) <<< 3) + (29'(temp_term_s2) <<< 1);
		t_full_c = 19'(t10_s3 >>> 10) + $signed({8'b0, TEMP_BASE});
		n_c   = 47'(prod_s4) - (47'(o1_s4) <<< 12);
		p_full_c = 29'(n_c >>> 19) + $signed({9'b0, PRESS_BASE});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= sample.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			dt_s1  <= dt_c;
			d1m_s1 <= d1m_c;
		end
		if (en_s2) begin
			sens_term_s2 <= $signed({1'b0, c3}) * dt_s1;
			off_term_s2  <= c4m_c * dt_s1;
			temp_term_s2 <= $signed({1'b0, c6p_c}) * dt_s1;
			d1m_s2       <= d1m_s1;
		end
		if (en_s3) begin
			s1_s3  <= s1_c;
			o1_s3  <= o1_c;
			t10_s3 <= t10_c;
			d1m_s3 <= d1m_s2;
		end
		if (en_s4) begin
			prod_s4 <= s1_s3 * d1m_s3;
			o1_s4   <= o1_s3;
			if (t_full_c > T_MAX)
				temp_s4 <= T_MAX[TEMP_W-1:0];
			else if (t_full_c < T_MIN)
				temp_s4 <= T_MIN[TEMP_W-1:0];
			else
				temp_s4 <= t_full_c[TEMP_W-1:0];
		end
		if (en_s5) begin
			temp_s5 <= temp_s4;
			if (p_full_c > P_MAX)
				press_s5 <= P_MAX[PRESS_W-1:0];
			else if (p_full_c < P_MIN)
				press_s5 <= P_MIN[PRESS_W-1:0];
			else
				press_s5 <= p_full_c[PRESS_W-1:0];
		end
	end

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> v_s1)
		else $error("accepted word did not enter first stage");

	a_block_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5))
		else $error("input blocked while pipeline has a bubble");

	a_last_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && en_s5) |=> v_s5)
		else $error("word lost between last two stages");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s4 && result.valid && result.ready) |=> !result.valid)
		else $error("result word repeated");
endmodule
`default_nettype wire

### hdl/psc_apb_regs.sv
`default_nettype none
module psc_apb_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [psc_pkg::APB_AW-1:0] paddr,
	input  logic [psc_pkg::APB_DW-1:0] pwdata,
	output logic [psc_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output psc_pkg::cal_words_t        cal
);
	import psc_pkg::*;

	cal_words_t cal_q;
	reg_index_t idx;
	logic       wr_en;

	assign idx    = reg_index_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cal    = cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_CAL_ONE:   cal_q.w1 <= pwdata[CAL_W-1:0];
				REG_CAL_TWO:   cal_q.w2 <= pwdata[CAL_W-1:0];
				REG_CAL_THREE: cal_q.w3 <= pwdata[CAL_W-1:0];
				REG_CAL_FOUR:  cal_q.w4 <= pwdata[CAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_CAL_ONE:   prdata[CAL_W-1:0] = cal_q.w1;
			REG_CAL_TWO:   prdata[CAL_W-1:0] = cal_q.w2;
			REG_CAL_THREE: prdata[CAL_W-1:0] = cal_q.w3;
			REG_CAL_FOUR:  prdata[CAL_W-1:0] = cal_q.w4;
			default:       prdata = '0;
		endcase
	end
endmodule
`default_nettype wire
